### rtl/core/ffsd_pkg.sv
package ffsd_pkg;

  localparam int STAMP_BITS_DEF = 32;

  localparam int FREQ_W  = 14;
  localparam int TMO_W   = 24;
  localparam int SINCE_W = 24;
  localparam int ETH_W   = 7;
  localparam int TEMP_W  = 12;
  localparam int CFG_DW  = 32;
  localparam int CFG_AW  = 4;

  // Frequency = 1e6 / period; the quotient fits 20 bits.
  localparam int FREQ_NUM      = 1000000;
  localparam int FREQ_NUM_BITS = 20;
  // (freq - low) * 100 stays below 2^21.
  localparam int ETH_NUM_BITS  = 21;
  localparam int PCT           = 100;
  localparam int PCT_BITS      = 7;

  localparam int DUTY_LO    = 10;
  localparam int DUTY_HI    = 90;
  // 16500 / 800 reduces to 165 / 8
  localparam int TEMP_SLOPE = 165;
  localparam int TEMP_SHIFT = 3;
  localparam int TEMP_MIN   = -400;
  localparam int TEMP_MAX   = 1250;

  localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};

  localparam logic [FREQ_W-1:0] FREQ_LO_RST = 14'd50;
  localparam logic [FREQ_W-1:0] FREQ_HI_RST = 14'd150;
  localparam logic [TMO_W-1:0]  TMO_RST     = 24'd500000;

  // register index (paddr[3:2])
  localparam logic [1:0] REG_FREQ_LO = 2'd0;
  localparam logic [1:0] REG_FREQ_HI = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  typedef enum logic [1:0] {
    DIV_FREQ,
    DIV_ETH,
    DIV_DUTY
  } div_sel_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_lo;
    logic [FREQ_W-1:0] freq_hi;
    logic [TMO_W-1:0]  timeout;
  } cfg_t;

  typedef struct packed {
    logic     upd;        // apply the accepted request to the timing state
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_freq;
    logic     cap_eth;
    logic     eth_clamp;  // ethanol from clamps, no division
    logic     cap_temp;
    logic     temp_floor; // temperature at its lower clamp
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic period_zero;
    logic eth_mid;
    logic duty_skip;
  } dp_sts_t;

endpackage

### rtl/core/ffsd_in_if.sv
interface ffsd_in_if;
  logic valid;
  logic ready;
  logic command;
  logic level;

  modport source (output valid, output command, output level, input ready);
  modport sink   (input valid, input command, input level, output ready);
endinterface

### rtl/core/ffsd_out_if.sv
interface ffsd_out_if;
  logic                                valid;
  logic                                ready;
  logic [ffsd_pkg::ETH_W-1:0]          ethanol_pct;
  logic signed [ffsd_pkg::TEMP_W-1:0]  temp_x10;
  logic                                valid_res;

  modport source (output valid, output ethanol_pct, output temp_x10, output valid_res,
                  input ready);
  modport sink   (input valid, input ethanol_pct, input temp_x10, input valid_res,
                  output ready);
endinterface

### rtl/core/ffsd_div.sv
// Restoring divider, one quotient bit per cycle. The numerator comes in
// left-aligned so that after 'steps' steps the register holds the quotient.
module ffsd_div #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 32,
  parameter int CNT_W = $clog2(NUM_W + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [CNT_W-1:0] steps,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] nq_r, nq_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DEN_W:0]   sh;
  logic             ge;

  always_comb begin
    sh  = {rem_r, nq_r[NUM_W-1]};
    ge  = (sh >= {1'b0, den_r});
    rem_nxt  = rem_r;
    nq_nxt   = nq_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      nq_nxt   = num;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(sh - {1'b0, den_r}) : sh[DEN_W-1:0];
      nq_nxt  = {nq_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = nq_r;

endmodule

### rtl/core/ffsd_datapath.sv
module ffsd_datapath #(
  parameter int STAMP_BITS = ffsd_pkg::STAMP_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ffsd_pkg::cfg_t                      cfg,
  input  ffsd_pkg::dp_cmd_t                   cmd,
  input  logic                                in_command,
  input  logic                                in_level,
  output ffsd_pkg::dp_sts_t                   sts,
  output logic [ffsd_pkg::ETH_W-1:0]          eth_out,
  output logic signed [ffsd_pkg::TEMP_W-1:0]  temp_out,
  output logic                                vld_out
);

  localparam int NUM_W  = STAMP_BITS + ffsd_pkg::PCT_BITS;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int FNB    = ffsd_pkg::FREQ_NUM_BITS;
  localparam int ENB    = ffsd_pkg::ETH_NUM_BITS;
  localparam int FW     = ffsd_pkg::FREQ_W;
  localparam int TW     = ffsd_pkg::TEMP_W;
  localparam int PROD_W = ffsd_pkg::PCT_BITS + 8;

  // timing state
  logic [STAMP_BITS-1:0]            now_r, now_nxt;
  logic [STAMP_BITS-1:0]            last_r, last_nxt;
  logic [STAMP_BITS-1:0]            period_r, period_nxt;
  logic [STAMP_BITS-1:0]            high_r, high_nxt;
  logic                             seen_r, seen_nxt;
  logic [ffsd_pkg::SINCE_W-1:0]     since_r, since_nxt;

  logic [FNB-1:0]                   freq_r;
  logic [ffsd_pkg::ETH_W-1:0]       eth_r;
  logic signed [TW-1:0]             temp_r;
  logic [ffsd_pkg::ETH_W-1:0]       eth_out_r;
  logic signed [TW-1:0]             temp_out_r;
  logic                             vld_out_r;

  logic [NUM_W-1:0]                 div_num, quo;
  logic [STAMP_BITS-1:0]            div_den;
  logic [CNT_W-1:0]                 div_steps;
  logic                             div_done;

  logic [FNB-1:0]                   flo_ext, fhi_ext, fdiff;
  logic [FW-1:0]                    span;
  logic [ENB-1:0]                   eth_num;
  logic                             f_le_lo, f_ge_hi;
  logic [ffsd_pkg::PCT_BITS-1:0]    dq;
  logic [PROD_W-1:0]                prod;
  logic signed [TW-1:0]             temp_calc;

  always_comb begin
    now_nxt    = now_r;
    last_nxt   = last_r;
    period_nxt = period_r;
    high_nxt   = high_r;
    seen_nxt   = seen_r;
    since_nxt  = since_r;
    if (cmd.upd) begin
      if (in_command == ffsd_pkg::CMD_TICK) begin
        now_nxt = now_r + 1'b1;
        if (since_r != ffsd_pkg::SINCE_MAX) since_nxt = since_r + 1'b1;
      end else begin
        if (in_level) begin
          if (seen_r && (last_r != '0)) period_nxt = now_r - last_r;
          last_nxt = now_r;
          seen_nxt = 1'b1;
        end else if (seen_r) begin
          high_nxt = now_r - last_r;
        end
        since_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r    <= '0;
      last_r   <= '0;
      period_r <= '0;
      high_r   <= '0;
      seen_r   <= 1'b0;
      since_r  <= '0;
    end else begin
      now_r    <= now_nxt;
      last_r   <= last_nxt;
      period_r <= period_nxt;
      high_r   <= high_nxt;
      seen_r   <= seen_nxt;
      since_r  <= since_nxt;
    end
  end

  // ethanol mapping
  always_comb begin
    flo_ext = FNB'(cfg.freq_lo);
    fhi_ext = FNB'(cfg.freq_hi);
    f_le_lo = (freq_r <= flo_ext);
    f_ge_hi = (freq_r >= fhi_ext);
    fdiff   = freq_r - flo_ext;
    span    = cfg.freq_hi - cfg.freq_lo;
    // only used when low < freq < high, so the difference fits FREQ_W bits
    eth_num = ENB'(fdiff[FW-1:0]) * ENB'(ffsd_pkg::PCT);
  end

  // divider operand select
  always_comb begin
    div_num   = {FNB'(ffsd_pkg::FREQ_NUM), {(NUM_W-FNB){1'b0}}};
    div_den   = period_r;
    div_steps = CNT_W'(FNB);
    case (cmd.div_sel)
      ffsd_pkg::DIV_ETH: begin
        div_num   = {eth_num, {(NUM_W-ENB){1'b0}}};
        div_den   = STAMP_BITS'(span);
        div_steps = CNT_W'(ENB);
      end
      ffsd_pkg::DIV_DUTY: begin
        div_num   = NUM_W'(high_r) * NUM_W'(ffsd_pkg::PCT);
        div_den   = period_r;
        div_steps = CNT_W'(NUM_W);
      end
      default: ;
    endcase
  end

  ffsd_div #(
    .NUM_W (NUM_W),
    .DEN_W (STAMP_BITS),
    .CNT_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (quo)
  );

  // temperature from duty quotient
  always_comb begin
    dq   = quo[ffsd_pkg::PCT_BITS-1:0] - ffsd_pkg::PCT_BITS'(ffsd_pkg::DUTY_LO);
    prod = PROD_W'(dq) * PROD_W'(ffsd_pkg::TEMP_SLOPE);
    if (quo <= NUM_W'(ffsd_pkg::DUTY_LO))
      temp_calc = TW'(ffsd_pkg::TEMP_MIN);
    else if (quo >= NUM_W'(ffsd_pkg::DUTY_HI))
      temp_calc = TW'(ffsd_pkg::TEMP_MAX);
    else
      temp_calc = TW'(ffsd_pkg::TEMP_MIN) + TW'(prod >> ffsd_pkg::TEMP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_freq) freq_r <= quo[FNB-1:0];
    if (cmd.cap_eth) eth_r <= quo[ffsd_pkg::ETH_W-1:0];
    else if (cmd.eth_clamp)
      eth_r <= ((period_r == '0) || f_le_lo) ? '0 : ffsd_pkg::ETH_W'(ffsd_pkg::PCT);
    if (cmd.cap_temp) temp_r <= temp_calc;
    else if (cmd.temp_floor) temp_r <= TW'(ffsd_pkg::TEMP_MIN);
    if (cmd.out_load) begin
      eth_out_r  <= eth_r;
      temp_out_r <= temp_r;
      vld_out_r  <= (since_r < cfg.timeout) && (period_r != '0);
    end
  end

  assign sts.div_done    = div_done;
  assign sts.period_zero = (period_r == '0);
  assign sts.eth_mid     = !f_le_lo && !f_ge_hi;
  assign sts.duty_skip   = (period_r == '0) || (high_r == '0);

  assign eth_out  = eth_out_r;
  assign temp_out = temp_out_r;
  assign vld_out  = vld_out_r;

endmodule

### rtl/core/ffsd_ctrl.sv
module ffsd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ffsd_pkg::dp_sts_t  sts,
  output ffsd_pkg::dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_FREQ     = 8'b0000_0010,
    S_FREQ_RUN = 8'b0000_0100,
    S_ETH      = 8'b0000_1000,
    S_ETH_RUN  = 8'b0001_0000,
    S_DUTY     = 8'b0010_0000,
    S_DUTY_RUN = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovld_r, ovld_nxt;
  logic   out_free;

  assign out_free = !ovld_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = ffsd_pkg::DIV_FREQ;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.upd   = 1'b1;
          state_nxt = S_FREQ;
        end
      end
      S_FREQ: begin
        if (sts.period_zero) begin
          cmd.eth_clamp = 1'b1;
          state_nxt     = S_DUTY;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_FREQ_RUN;
        end
      end
      S_FREQ_RUN: begin
        if (sts.div_done) begin
          cmd.cap_freq = 1'b1;
          state_nxt    = S_ETH;
        end
      end
      S_ETH: begin
        cmd.div_sel = ffsd_pkg::DIV_ETH;
        if (sts.eth_mid) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_ETH_RUN;
        end else begin
          cmd.eth_clamp = 1'b1;
          state_nxt     = S_DUTY;
        end
      end
      S_ETH_RUN: begin
        if (sts.div_done) begin
          cmd.cap_eth = 1'b1;
          state_nxt   = S_DUTY;
        end
      end
      S_DUTY: begin
        cmd.div_sel = ffsd_pkg::DIV_DUTY;
        if (sts.duty_skip) begin
          cmd.temp_floor = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DUTY_RUN;
        end
      end
      S_DUTY_RUN: begin
        if (sts.div_done) begin
          cmd.cap_temp = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (cmd.out_load) ovld_nxt = 1'b1;
    else if (out_ready) ovld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovld_r;

endmodule

### rtl/core/flex_fuel_sensor_decoder.sv
// Flex-fuel sensor decoder. Each input request is a 1 us tick (command 0) or
// a pin edge (command 1, level = new pin level); each request yields exactly
// one result: ethanol percent, fuel temperature in 0.1 C and a valid flag.
// One request is in work at a time. The timing state is updated first,
// then come up to three passes of a shared one-bit-per-cycle restoring
// divider: 1e6/period (20 steps), the ethanol scale (21 steps, skipped when
// the frequency clamps) and the duty (STAMP_BITS+7 steps, skipped when period
// or high time is zero); a zero period skips the first two. A finished
// result sits in an output register, so the next request is taken while it
// waits. Config registers at byte 0x0 (freq_low_hz), 0x4 (freq_high_hz), 0x8
// (timeout_us); write them only idle.
module flex_fuel_sensor_decoder #(
  parameter int STAMP_BITS = ffsd_pkg::STAMP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ffsd_in_if.sink                        in_ch,
  ffsd_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ffsd_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [ffsd_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [ffsd_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);

  ffsd_pkg::cfg_t    cfg_r, cfg_nxt;
  ffsd_pkg::dp_cmd_t cmd;
  ffsd_pkg::dp_sts_t sts;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  // config port: no wait states
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        ffsd_pkg::REG_FREQ_LO: cfg_nxt.freq_lo = cfg_pwdata[ffsd_pkg::FREQ_W-1:0];
        ffsd_pkg::REG_FREQ_HI: cfg_nxt.freq_hi = cfg_pwdata[ffsd_pkg::FREQ_W-1:0];
        ffsd_pkg::REG_TIMEOUT: cfg_nxt.timeout = cfg_pwdata[ffsd_pkg::TMO_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ffsd_pkg::REG_FREQ_LO: cfg_prdata = ffsd_pkg::CFG_DW'(cfg_r.freq_lo);
      ffsd_pkg::REG_FREQ_HI: cfg_prdata = ffsd_pkg::CFG_DW'(cfg_r.freq_hi);
      ffsd_pkg::REG_TIMEOUT: cfg_prdata = ffsd_pkg::CFG_DW'(cfg_r.timeout);
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freq_lo <= ffsd_pkg::FREQ_LO_RST;
      cfg_r.freq_hi <= ffsd_pkg::FREQ_HI_RST;
      cfg_r.timeout <= ffsd_pkg::TMO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer: owns the handshakes and the output-valid flag
  ffsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // timing state, shared divider and result registers
  ffsd_datapath #(
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .in_command (in_ch.command),
    .in_level   (in_ch.level),
    .sts        (sts),
    .eth_out    (out_ch.ethanol_pct),
    .temp_out   (out_ch.temp_x10),
    .vld_out    (out_ch.valid_res)
  );

endmodule
